@@ sv/rfc_pkg.sv @@
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared types, constants and saturating arithmetic helpers for the
// false-position cubic root finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rfc_pkg;

  localparam int DataWidth = 32;
  localparam int FracBits  = 16;
  localparam int DivSteps  = DataWidth + FracBits;
  localparam int CntWidth  = $clog2(DivSteps + 1);

  localparam logic signed [DataWidth-1:0] MaxVal = {1'b0, {(DataWidth-1){1'b1}}};
  localparam logic signed [DataWidth-1:0] MinVal = {1'b1, {(DataWidth-1){1'b0}}};
  localparam logic signed [DataWidth-1:0] OneVal =
      DataWidth'(64'(1) << FracBits);

  // Result status codes.
  typedef enum logic [1:0] {
    ST_CONV    = 2'd0,
    ST_NOCONV  = 2'd1,
    ST_INVALID = 2'd2,
    ST_ZERODEN = 2'd3
  } status_t;

  // Which bracket value a function evaluation works on.
  typedef enum logic [1:0] {
    VS_A,
    VS_B,
    VS_X
  } vsel_t;

  // Operand pairs for the shared multiplier.
  typedef enum logic [1:0] {
    MUL_SQ,
    MUL_CU,
    MUL_AFB,
    MUL_BFA
  } mulsel_t;

  typedef struct packed {
    logic    load;
    logic    mul_go;
    mulsel_t mul_sel;
    vsel_t   vsel;
    logic    t_ld;
    logic    f_ld;
    logic    num_ld;
    logic    div_go;
    logic    x_ld;
    logic    upd;
  } cmd_t;

  typedef struct packed {
    logic invalid;
    logic den_zero;
    logic div_done;
    logic opp;
    logic conv;
  } stat_t;

  // Magnitude of a signed word.
  function automatic logic [DataWidth-1:0] mag(input logic signed [DataWidth-1:0] v);
    mag = v[DataWidth-1] ? DataWidth'(-v) : DataWidth'(v);
  endfunction

  // Signed value from sign and wide magnitude, saturated.
  function automatic logic signed [DataWidth-1:0] from_mag(
      input logic neg, input logic [DivSteps-1:0] m);
    logic [DivSteps-1:0] lim;
    lim = neg ? DivSteps'(MaxVal) + DivSteps'(1) : DivSteps'(MaxVal);
    if (m > lim) begin
      from_mag = neg ? MinVal : MaxVal;
    end else begin
      from_mag = neg ? DataWidth'(-m) : DataWidth'(m);
    end
  endfunction

  // Saturating difference.
  function automatic logic signed [DataWidth-1:0] sat_sub(
      input logic signed [DataWidth-1:0] a, input logic signed [DataWidth-1:0] b);
    logic signed [DataWidth:0] d;
    d = (DataWidth+1)'(a) - (DataWidth+1)'(b);
    if (d > (DataWidth+1)'(MaxVal)) begin
      sat_sub = MaxVal;
    end else if (d < (DataWidth+1)'(MinVal)) begin
      sat_sub = MinVal;
    end else begin
      sat_sub = d[DataWidth-1:0];
    end
  endfunction

endpackage

`default_nettype wire

@@ sv/rfc_div.sv @@
// ----------------------------------------------------------------------------
// rfc_div
// Restoring fixed-point divider, one quotient bit per cycle, saturated result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rfc_div (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic signed [rfc_pkg::DataWidth-1:0] num,
  input  wire logic signed [rfc_pkg::DataWidth-1:0] den,
  output logic                                     done,
  output logic signed [rfc_pkg::DataWidth-1:0]     quo
);
  import rfc_pkg::*;

  logic [DataWidth-1:0] ud;
  logic [DataWidth-1:0] rem;
  logic [DivSteps-1:0]  qd;
  logic                 neg;
  logic [CntWidth-1:0]  cnt;
  logic                 busy;
  logic [DataWidth:0]   trial;
  logic                 fits;

  // Shift the next dividend bit into the partial remainder and test it.
  assign trial = {rem, qd[DivSteps-1]};
  assign fits  = trial >= {1'b0, ud};

  // Control: step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntWidth'(DivSteps);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntWidth'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and combined dividend and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      ud  <= mag(den);
      rem <= '0;
      qd  <= {mag(num), {FracBits{1'b0}}};
      neg <= num[DataWidth-1] ^ den[DataWidth-1];
    end else if (busy) begin
      rem <= fits ? DataWidth'(trial - {1'b0, ud}) : trial[DataWidth-1:0];
      qd  <= {qd[DivSteps-2:0], fits};
    end
  end

  assign quo = from_mag(neg, qd);

endmodule

`default_nettype wire

@@ sv/rfc_datapath.sv @@
// ----------------------------------------------------------------------------
// rfc_datapath
// Bracket registers, shared multiplier, function evaluation and divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rfc_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire rfc_pkg::cmd_t                       cmd,
  input  wire logic signed [rfc_pkg::DataWidth-1:0] low_guess,
  input  wire logic signed [rfc_pkg::DataWidth-1:0] high_guess,
  input  wire logic [15:0]                         tolerance,
  output rfc_pkg::stat_t                           stat,
  output logic signed [rfc_pkg::DataWidth-1:0]     x_out
);
  import rfc_pkg::*;

  logic signed [DataWidth-1:0] a, b, x, fa, fb, fx, t, num;
  logic signed [DataWidth-1:0] v, ml, mr, qres, den, quo, diff;
  logic [2*DataWidth-1:0]      prod;
  logic                        pneg;
  logic                        div_done;

  // Value under evaluation.
  always_comb begin
    unique case (cmd.vsel)
      VS_A:    v = a;
      VS_B:    v = b;
      default: v = x;
    endcase
  end

  // Multiplier operand selection.
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_SQ:  begin ml = v; mr = v;  end
      MUL_CU:  begin ml = t; mr = v;  end
      MUL_AFB: begin ml = a; mr = fb; end
      default: begin ml = b; mr = fa; end
    endcase
  end

  // Registered magnitude product and its sign.
  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      prod <= mag(ml) * mag(mr);
      pneg <= ml[DataWidth-1] ^ mr[DataWidth-1];
    end
  end

  assign qres = from_mag(pneg, prod[2*DataWidth-1:FracBits]);
  assign den  = sat_sub(fb, fa);
  assign diff = sat_sub(quo, x);

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a <= low_guess;
      b <= high_guess;
    end
    if (cmd.t_ld) begin
      t <= qres;
    end
    if (cmd.f_ld) begin
      unique case (cmd.vsel)
        VS_A:    fa <= sat_sub(sat_sub(qres, v), OneVal);
        VS_B:    fb <= sat_sub(sat_sub(qres, v), OneVal);
        default: fx <= sat_sub(sat_sub(qres, v), OneVal);
      endcase
    end
    if (cmd.num_ld) begin
      num <= sat_sub(t, qres);
    end
    if (cmd.x_ld) begin
      x <= quo;
    end
    // Replace the bracket end on the same side as the new point.
    if (cmd.upd) begin
      if (stat.opp) begin
        b  <= x;
        fb <= fx;
      end else begin
        a  <= x;
        fa <= fx;
      end
    end
  end

  rfc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_go),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quo   (quo)
  );

  // Status toward the controller.
  always_comb begin
    stat.invalid  = ((fa > 0) && (fb > 0)) || ((fa < 0) && (fb < 0));
    stat.den_zero = den == '0;
    stat.div_done = div_done;
    stat.opp      = ((fa < 0) && (fx > 0)) || ((fa > 0) && (fx < 0));
    stat.conv     = mag(diff) < DataWidth'(tolerance);
  end

  assign x_out = x;

endmodule

`default_nettype wire

@@ sv/rfc_ctrl.sv @@
// ----------------------------------------------------------------------------
// rfc_ctrl
// Sequencer for function evaluation, secant step and iteration control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rfc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             out_free,
  input  wire logic [5:0]       limit,
  input  wire rfc_pkg::stat_t   stat,
  output rfc_pkg::cmd_t         cmd,
  output logic                  idle,
  output logic                  emit,
  output rfc_pkg::status_t      code,
  output logic [5:0]            iter
);
  import rfc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_T, S_CU, S_F, S_CHECK, S_SEC, S_M1, S_MT, S_M2,
    S_SUB, S_DIV, S_WAIT, S_UPD, S_DONE
  } state_t;

  state_t      state;
  vsel_t       phase;
  logic [5:0]  lim;

  assign lim = (limit == '0) ? 6'd1 : limit;

  // State, evaluation phase, iteration count and result code.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= VS_A;
      iter  <= '0;
      code  <= ST_CONV;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            phase <= VS_A;
            iter  <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: state <= S_T;
        S_T:  state <= S_CU;
        S_CU: state <= S_F;
        S_F: begin
          unique case (phase)
            VS_A: begin
              phase <= VS_B;
              state <= S_SQ;
            end
            VS_B:    state <= S_CHECK;
            default: state <= S_UPD;
          endcase
        end
        S_CHECK: begin
          if (stat.invalid) begin
            code  <= ST_INVALID;
            state <= S_DONE;
          end else begin
            state <= S_SEC;
          end
        end
        S_SEC: begin
          if (stat.den_zero) begin
            code  <= ST_ZERODEN;
            state <= S_DONE;
          end else begin
            state <= S_M1;
          end
        end
        S_M1:  state <= S_MT;
        S_MT:  state <= S_M2;
        S_M2:  state <= S_SUB;
        S_SUB: state <= S_DIV;
        S_DIV: state <= S_WAIT;
        S_WAIT: begin
          if (stat.div_done) begin
            priority if (iter == '0) begin
              iter  <= 6'd1;
              phase <= VS_X;
              state <= S_SQ;
            end else if (stat.conv) begin
              code  <= ST_CONV;
              state <= S_DONE;
            end else if (iter >= lim) begin
              code  <= ST_NOCONV;
              iter  <= lim;
              state <= S_DONE;
            end else begin
              iter  <= iter + 1'b1;
              phase <= VS_X;
              state <= S_SQ;
            end
          end
        end
        S_UPD: state <= S_SEC;
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath commands decoded from the state.
  always_comb begin
    cmd         = '0;
    cmd.vsel    = phase;
    cmd.mul_sel = MUL_SQ;
    unique case (state)
      S_IDLE: cmd.load = start;
      S_SQ:   cmd.mul_go = 1'b1;
      S_T:    cmd.t_ld = 1'b1;
      S_CU: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_CU;
      end
      S_F: cmd.f_ld = 1'b1;
      S_M1: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_AFB;
      end
      S_MT: cmd.t_ld = 1'b1;
      S_M2: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_sel = MUL_BFA;
      end
      S_SUB:  cmd.num_ld = 1'b1;
      S_DIV:  cmd.div_go = 1'b1;
      S_WAIT: cmd.x_ld = stat.div_done && ((iter == '0) || !stat.conv);
      S_UPD:  cmd.upd = 1'b1;
      default: ;
    endcase
  end

  assign idle = state == S_IDLE;
  assign emit = state == S_DONE;

endmodule

`default_nettype wire

@@ sv/regula_falsi_cubic_root_top.sv @@
// From the input transfer to the loaded output register, an invalid bracket ends
// at the bracket check, a zero denominator at the initial secant point ends at the
// secant step, and otherwise every iteration waits on the 48-step bit-serial
// divider. Throughput: one item at a time; the next item is accepted once the
// result has moved into the output register.
// Synchronous active-high reset idles the controller, empties the output, and loads tolerance 7, limit 11.
// ----------------------------------------------------------------------------
// regula_falsi_cubic_root_top
// False-position root finder for x^3 - x - 1 in signed Q16.16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module regula_falsi_cubic_root_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] low_guess,
  input  wire logic signed [31:0] high_guess,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      root,
  output logic [1:0]              status,
  output logic [5:0]              iterations_used,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import rfc_pkg::*;

  localparam logic CfgTol = 1'b0;

  logic [15:0]                 tolerance;
  logic [5:0]                  iteration_limit;
  cmd_t                        cmd;
  stat_t                       stat;
  logic                        idle, emit, out_free;
  status_t                     code;
  logic [5:0]                  iter;
  logic signed [DataWidth-1:0] x;

  assign cfg_ready = 1'b1;
  assign in_ready  = idle;
  assign out_free  = !out_valid || out_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance       <= 16'd7;
      iteration_limit <= 6'd11;
    end else if (cfg_valid) begin
      if (cfg_index == CfgTol) begin
        tolerance <= cfg_data;
      end else begin
        iteration_limit <= cfg_data[5:0];
      end
    end
  end

  rfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (in_valid && idle),
    .out_free (out_free),
    .limit    (iteration_limit),
    .stat     (stat),
    .cmd      (cmd),
    .idle     (idle),
    .emit     (emit),
    .code     (code),
    .iter     (iter)
  );

  rfc_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .low_guess  (low_guess),
    .high_guess (high_guess),
    .tolerance  (tolerance),
    .stat       (stat),
    .x_out      (x)
  );

  // Output register; a finished result waits here for its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && out_free) begin
      root            <= (code == ST_CONV) ? x : '0;
      status          <= code;
      iterations_used <= (code == ST_INVALID) ? 6'd0 : iter;
    end
  end

endmodule

`default_nettype wire

@@ tb/regula_falsi_cubic_root_checker.sv @@
// ----------------------------------------------------------------------------
// regula_falsi_cubic_root_checker
// Watches the configuration, input and result channels of the root finder,
// predicts every result from its own model of the fixed-point iteration and
// compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module regula_falsi_cubic_root_checker
  import rfc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] low_guess,
  input  logic signed [31:0] high_guess,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] root,
  input  logic [1:0]         status,
  input  logic [5:0]         iterations_used,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 errors,
  output int                 pending
);

  localparam logic CfgTolerance = 1'b0;
  localparam logic CfgIterLimit = 1'b1;
  localparam longint QMax = 64'sd2147483647;
  localparam longint QMin = -64'sd2147483648;
  localparam longint QOne = 64'sd65536;

  typedef struct packed {
    logic signed [31:0] root;
    status_t            status;
    logic [5:0]         iters;
  } root_result_t;

  root_result_t expected_roots[$];
  logic [15:0]  tol_q;
  logic [5:0]   limit_q;

  function automatic longint clamp_q(longint v);
    if (v > QMax) return QMax;
    if (v < QMin) return QMin;
    return v;
  endfunction

  function automatic longint signed_mag(bit neg, longint m);
    longint lim;
    lim = neg ? QMax + 1 : QMax;
    if (m > lim) m = lim;
    return neg ? -m : m;
  endfunction

  function automatic longint abs_q(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return signed_mag((a < 0) != (b < 0), (abs_q(a) * abs_q(b)) >>> 16);
  endfunction

  function automatic longint fx_div(longint n, longint d);
    return signed_mag((n < 0) != (d < 0), (abs_q(n) <<< 16) / abs_q(d));
  endfunction

  function automatic longint cubic(longint x);
    return clamp_q(clamp_q(fx_mul(fx_mul(x, x), x) - x) - QOne);
  endfunction

  // Secant point of the bracket; flags a zero slope denominator.
  function automatic longint false_position(longint a, longint b, output bit zero);
    longint fa, fb, den;
    fa = cubic(a);
    fb = cubic(b);
    den = clamp_q(fb - fa);
    zero = (den == 0);
    if (zero) return 0;
    return fx_div(clamp_q(fx_mul(a, fb) - fx_mul(b, fa)), den);
  endfunction

  function automatic root_result_t solve_bracket(logic signed [31:0] lo,
                                                 logic signed [31:0] hi);
    root_result_t r;
    longint a, b, x, nx, fa, fb, fx;
    bit zero;
    int lim;
    a = lo;
    b = hi;
    lim = (limit_q == 0) ? 1 : int'(limit_q);
    r = '0;
    fa = cubic(a);
    fb = cubic(b);
    if ((fa > 0 && fb > 0) || (fa < 0 && fb < 0)) begin
      r.status = ST_INVALID;
      return r;
    end
    x = false_position(a, b, zero);
    if (zero) begin
      r.status = ST_ZERODEN;
      return r;
    end
    for (int it = 1; it <= lim; it++) begin
      fa = cubic(a);
      fx = cubic(x);
      if ((fa < 0 && fx > 0) || (fa > 0 && fx < 0)) b = x;
      else a = x;
      nx = false_position(a, b, zero);
      if (zero) begin
        r.status = ST_ZERODEN;
        r.iters = 6'(it);
        return r;
      end
      if (abs_q(clamp_q(nx - x)) < longint'(tol_q)) begin
        r.root = 32'(x);
        r.status = ST_CONV;
        r.iters = 6'(it);
        return r;
      end
      x = nx;
    end
    r.status = ST_NOCONV;
    r.iters = 6'(lim);
    return r;
  endfunction

  assign pending = expected_roots.size();

  // Track registers, queue predictions and compare result transfers.
  always @(posedge clk) begin
    root_result_t want;
    if (rst) begin
      tol_q <= 16'd7;
      limit_q <= 6'd11;
      expected_roots.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CfgTolerance) tol_q <= cfg_data;
        else if (cfg_index == CfgIterLimit) limit_q <= cfg_data[5:0];
      end
      if (in_valid && in_ready) expected_roots.push_back(solve_bracket(low_guess, high_guess));
      if (out_valid && out_ready) begin
        if (expected_roots.size() == 0) begin
          if (errors < 10) $display("unexpected result root=%0d status=%0d iters=%0d",
                                    root, status, iterations_used);
          errors <= errors + 1;
        end else begin
          want = expected_roots.pop_front();
          if (want.root !== root || want.status !== status ||
              want.iters !== iterations_used) begin
            if (errors < 10)
              $display("mismatch: expected root=%0d status=%0d iters=%0d, got %0d %0d %0d",
                       want.root, want.status, want.iters, root, status,
                       iterations_used);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

@@ tb/regula_falsi_cubic_root_top_test.sv @@
// ----------------------------------------------------------------------------
// regula_falsi_cubic_root_top_test
// Drives brackets and register writes into the root finder with random idle
// and stall cycles; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module regula_falsi_cubic_root_top_test;
  import rfc_pkg::*;

  localparam logic CfgTolerance = 1'b0;
  localparam logic CfgIterLimit = 1'b1;
  localparam int   CycleLimit   = 20000000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] low_guess = '0;
  logic signed [31:0] high_guess = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] root;
  logic [1:0]         status;
  logic [5:0]         iterations_used;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = 1'b0;
  logic [15:0]        cfg_data = '0;
  int                 errors;
  int                 pending;
  bit                 calm = 1'b0;
  bit                 hold_off = 1'b0;

  regula_falsi_cubic_root_top u_dut (.*);

  regula_falsi_cubic_root_checker u_checker (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // Cycle limit guard.
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("regula_falsi_cubic_root_top verification failed");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else out_ready <= calm || ($urandom_range(99) >= 15);
  end

  task automatic send_bracket(logic signed [31:0] lo, logic signed [31:0] hi);
    if (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_valid <= 1'b1;
    low_guess <= lo;
    high_guess <= hi;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Register write once the block has drained.
  task automatic write_reg(logic idx, logic [15:0] value);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly brackets around the real root, sometimes anything at all.
  task automatic random_bracket();
    logic signed [31:0] lo, hi;
    if ($urandom_range(99) < 75) begin
      lo = $urandom_range(32'h0001_5000, 32'h0000_2000);
      hi = $urandom_range(32'h0004_0000, 32'h0001_6000);
      if ($urandom_range(1)) send_bracket(hi, lo);
      else send_bracket(lo, hi);
    end else if ($urandom_range(1)) begin
      send_bracket($urandom, $urandom);
    end else begin
      lo = $urandom_range(32'h0001_0000) - 32'sh0000_8000;
      hi = $urandom_range(32'h0004_0000) - 32'sh0001_0000;
      send_bracket(lo, hi);
    end
  endtask

  task automatic run_phase(logic [15:0] tol, logic [5:0] lim, int count);
    write_reg(CfgTolerance, tol);
    write_reg(CfgIterLimit, {10'd0, lim});
    repeat (count) random_bracket();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed brackets at reset settings.
    send_bracket(32'sh0001_0000, 32'sh0002_0000);
    send_bracket(32'sh0002_0000, 32'sh0001_0000);
    send_bracket(32'sh0002_0000, 32'sh0003_0000);
    send_bracket(-32'sh0002_0000, -32'sh0001_0000);
    send_bracket(32'sh7fff_ffff, 32'sh8000_0000);
    send_bracket(32'sh8000_0000, 32'sh7fff_ffff);
    send_bracket(32'sh0000_0000, 32'sh7fff_ffff);
    send_bracket(32'sh8000_0000, 32'sh0000_0000);
    send_bracket(32'sh0001_5330, 32'sh0001_5330);
    send_bracket(32'sh0001_0000, 32'sh0001_0000);
    send_bracket(32'sh0000_0000, 32'sh0000_0000);
    send_bracket(32'sh0000_0001, 32'sh0001_ffff);
    send_bracket(32'shffff_ffff, 32'sh0010_0000);
    send_bracket(32'sh7fff_0000, 32'sh0000_0000);

    // Pressure: results held back while brackets keep coming.
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (6) random_bracket();
    join

    repeat (150) random_bracket();
    calm = 1'b1;
    repeat (120) random_bracket();
    calm = 1'b0;

    run_phase(16'd0, 6'd1, 60);
    run_phase(16'hffff, 6'd63, 80);
    run_phase(16'd0, 6'd0, 40);
    run_phase(16'd1, 6'd63, 25);
    run_phase(16'd0, 6'd63, 15);
    run_phase(16'd7, 6'd11, 100);
    for (int p = 0; p < 8; p++)
      run_phase(16'($urandom), 6'($urandom_range(12, 1)), 50);
    run_phase(16'd7, 6'd11, 20);

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("regula_falsi_cubic_root_top verification clean");
    else $display("regula_falsi_cubic_root_top verification failed");
    $finish;
  end

endmodule
